FILE: src/lac_pkg.sv
package lac_pkg;

    localparam int MAX_LAGS    = 64;
    localparam int MAX_SAMPLES = 16384;
    localparam int SAMPLE_BITS = 24;

    localparam int DEV_W  = SAMPLE_BITS + 1;
    localparam int PROD_W = 2 * DEV_W;
    localparam int SUM_W  = 64;
    localparam int VAR_W  = 48;
    localparam int CNT_W  = 15;
    localparam int LAG_W  = 6;
    localparam int Q_W    = 18;
    localparam int DEN_W  = 63;
    localparam int FRAC_STEPS = 17;

    localparam logic [2:0] REG_MEAN_X   = 3'd0;
    localparam logic [2:0] REG_MEAN_Y   = 3'd1;
    localparam logic [2:0] REG_MEAN_Z   = 3'd2;
    localparam logic [2:0] REG_VAR_X    = 3'd3;
    localparam logic [2:0] REG_VAR_Y    = 3'd4;
    localparam logic [2:0] REG_VAR_Z    = 3'd5;
    localparam logic [2:0] REG_LAGCOUNT = 3'd6;

    typedef logic signed [DEV_W-1:0] t_dev;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef t_dev t_dev3 [3];
    typedef t_sum t_sum3 [3];

    typedef struct packed {
        logic dev_vld;
        logic prod_vld;
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_RUN,
        S_W1,
        S_W2,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_INIT,
        D_ITER
    } t_div_ph;

endpackage

FILE: src/lac_cell.sv
module lac_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lac_pkg::t_cell_ctrl i_ctrl,
    input  lac_pkg::t_dev3      i_dev,
    input  lac_pkg::t_dev3      i_d_in,
    output lac_pkg::t_dev3      o_d_out,
    input  lac_pkg::t_sum3      i_sum_in,
    output lac_pkg::t_sum3      o_sum_out
);
    import lac_pkg::*;

    t_dev r_tap [3];
    t_sum r_sum [3];
    logic signed [PROD_W-1:0] r_prod [3];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (i_ctrl.dev_vld) begin
                r_prod[a] <= PROD_W'(i_dev[a]) * PROD_W'(i_d_in[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (!i_rst_n || i_ctrl.clear) begin
                r_tap[a] <= '0;
                r_sum[a] <= '0;
            end else begin
                if (i_ctrl.dev_vld) begin
                    r_tap[a] <= i_d_in[a];
                end
                if (i_ctrl.shift) begin
                    r_sum[a] <= i_sum_in[a];
                end else if (i_ctrl.prod_vld) begin
                    r_sum[a] <= r_sum[a] + SUM_W'(r_prod[a]);
                end
            end
        end
    end

    assign o_d_out   = r_tap;
    assign o_sum_out = r_sum;

endmodule

FILE: src/lac_div.sv
module lac_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  lac_pkg::t_sum                    i_sum,
    input  logic [lac_pkg::CNT_W-1:0]        i_cnt,
    input  logic [lac_pkg::VAR_W-1:0]        i_var,
    output logic                             o_done,
    output logic signed [lac_pkg::Q_W-1:0]   o_q
);
    import lac_pkg::*;

    t_div_ph                r_ph, n_ph;
    logic [SUM_W-1:0]       r_mag;
    logic                   r_neg;
    logic [DEN_W-1:0]       r_den;
    logic [DEN_W-1:0]       r_rem;
    logic [Q_W-1:0]         r_f;
    logic                   r_sat;
    logic [4:0]             r_cnt;
    logic                   r_done;

    logic [VAR_W-1:0]       w_var;
    logic [SUM_W-1:0]       w_t;
    logic                   w_b;
    logic                   w_q0;
    logic [Q_W:0]           w_rnd;
    logic [Q_W-1:0]         w_mag;

    assign w_var = (i_var == '0) ? VAR_W'(1) : i_var;
    assign w_t   = {r_rem, 1'b0};
    assign w_b   = w_t >= {1'b0, r_den};
    assign w_q0  = r_mag >= {1'b0, r_den};

    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            D_IDLE: if (i_start) n_ph = D_INIT;
            D_INIT: n_ph = D_ITER;
            D_ITER: if (r_cnt == 5'(FRAC_STEPS - 1)) n_ph = D_IDLE;
            default: n_ph = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= (r_ph == D_ITER) && (r_cnt == 5'(FRAC_STEPS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_ph)
            D_IDLE: begin
                if (i_start) begin
                    r_neg <= i_sum[SUM_W-1];
                    r_mag <= i_sum[SUM_W-1] ? (SUM_W'(0) - i_sum) : i_sum;
                    r_den <= DEN_W'(i_cnt) * DEN_W'(w_var);
                end
            end
            D_INIT: begin
                r_sat <= r_mag >= {r_den, 1'b0};
                r_rem <= w_q0 ? DEN_W'(r_mag - {1'b0, r_den}) : DEN_W'(r_mag);
                r_f   <= Q_W'(w_q0);
                r_cnt <= '0;
            end
            D_ITER: begin
                r_rem <= w_b ? DEN_W'(w_t - {1'b0, r_den}) : DEN_W'(w_t);
                r_f   <= {r_f[Q_W-2:0], w_b};
                r_cnt <= r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

    // round half away from zero on the magnitude, then clamp per sign
    always_comb begin
        w_rnd = r_sat ? (Q_W+1)'(131073) : (({1'b0, r_f} + (Q_W+1)'(1)) >> 1);
        if (r_neg) begin
            w_mag = (w_rnd > (Q_W+1)'(131072)) ? Q_W'(131072) : Q_W'(w_rnd);
            o_q   = $signed(Q_W'(0) - w_mag);
        end else begin
            w_mag = (w_rnd > (Q_W+1)'(131071)) ? Q_W'(131071) : Q_W'(w_rnd);
            o_q   = $signed(w_mag);
        end
    end

    assign o_done = r_done;

endmodule

FILE: src/lag_autocorrelation.sv
// Samples are taken one per cycle while no run is being settled or reported.
// Sums settle through wait states W1 and W2 after the last sample; each lag then
// takes load, divider setup, 17 quotient-bit steps, done and emit in the dividers.
// A result waits in the output register until i_ready takes it, and the next lag
// is emitted only once that register is free.
// Synchronous active-low reset clears taps, sums, sample and lag counters, output valid;
// the run state is cleared in the cycle after each run's final result is emitted.
module lag_autocorrelation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [2:0]                          i_cfg_index,
    input  logic [lac_pkg::VAR_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [lac_pkg::SAMPLE_BITS-1:0] i_sample_x,
    input  logic signed [lac_pkg::SAMPLE_BITS-1:0] i_sample_y,
    input  logic signed [lac_pkg::SAMPLE_BITS-1:0] i_sample_z,
    input  logic                                i_last_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lac_pkg::LAG_W-1:0]           o_lag_index,
    output logic signed [lac_pkg::Q_W-1:0]      o_corr_x,
    output logic signed [lac_pkg::Q_W-1:0]      o_corr_y,
    output logic signed [lac_pkg::Q_W-1:0]      o_corr_z,
    output logic                                o_lag_valid,
    output logic                                o_overflowed,
    output logic                                o_last_lag
);
    import lac_pkg::*;

    logic signed [23:0] r_mean [3];
    logic [VAR_W-1:0]   r_var [3];
    logic [6:0]         r_lagcount;

    t_state             r_st, n_st;
    logic [CNT_W-1:0]   r_n;
    logic               r_drop;
    t_dev3              r_dev;
    logic               r_dev_vld;
    logic               r_prod_vld;
    logic [LAG_W-1:0]   r_lag;

    logic               r_o_vld;
    logic [LAG_W-1:0]   r_o_lag;
    logic signed [Q_W-1:0] r_o_corr [3];
    logic               r_o_lv;
    logic               r_o_ovf;
    logic               r_o_last;

    logic               w_acc;
    logic               w_slot;
    logic               w_emit;
    logic               w_final;
    logic               w_lv;
    logic [LAG_W-1:0]   w_lim;
    logic [CNT_W-1:0]   w_cnt;
    logic signed [SAMPLE_BITS-1:0] w_smp [3];
    t_cell_ctrl         w_ctrl;
    t_dev3              w_tap [MAX_LAGS+1];
    t_sum3              w_sum [MAX_LAGS+1];
    logic [2:0]         w_done;
    logic signed [Q_W-1:0] w_q [3];

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_st == S_RUN);
    assign w_acc       = i_valid && o_ready;
    assign w_slot      = !r_o_vld || i_ready;
    assign w_emit      = (r_st == S_EMIT) && w_slot;
    assign w_final     = w_emit && (r_lag == w_lim);
    assign w_lv        = {{(CNT_W-LAG_W){1'b0}}, r_lag} < r_n;
    assign w_cnt       = r_n - {{(CNT_W-LAG_W){1'b0}}, r_lag};
    assign w_smp[0]    = i_sample_x;
    assign w_smp[1]    = i_sample_y;
    assign w_smp[2]    = i_sample_z;

    always_comb begin
        priority if (r_lagcount == 7'd0) begin
            w_lim = '0;
        end else if (r_lagcount > 7'(MAX_LAGS)) begin
            w_lim = LAG_W'(MAX_LAGS - 1);
        end else begin
            w_lim = LAG_W'(r_lagcount - 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_mean[a] <= '0;
                r_var[a]  <= VAR_W'(1);
            end
            r_lagcount <= 7'(MAX_LAGS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MEAN_X:   r_mean[0]  <= i_cfg_data[23:0];
                REG_MEAN_Y:   r_mean[1]  <= i_cfg_data[23:0];
                REG_MEAN_Z:   r_mean[2]  <= i_cfg_data[23:0];
                REG_VAR_X:    r_var[0]   <= i_cfg_data;
                REG_VAR_Y:    r_var[1]   <= i_cfg_data;
                REG_VAR_Z:    r_var[2]   <= i_cfg_data;
                REG_LAGCOUNT: r_lagcount <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_RUN:  if (w_acc && i_last_sample) n_st = S_W1;
            S_W1:   n_st = S_W2;
            S_W2:   n_st = S_LOAD;
            S_LOAD: n_st = S_DIV;
            S_DIV:  if (w_done[0]) n_st = S_EMIT;
            S_EMIT: begin
                if (w_final) n_st = S_RUN;
                else if (w_emit) n_st = S_LOAD;
            end
            default: n_st = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_RUN;
            r_n        <= '0;
            r_drop     <= 1'b0;
            r_dev_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_lag      <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_dev_vld  <= w_acc && (r_n < CNT_W'(MAX_SAMPLES));
            r_prod_vld <= r_dev_vld;
            if (w_acc) begin
                if (r_n < CNT_W'(MAX_SAMPLES)) begin
                    r_n <= r_n + CNT_W'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (w_final) begin
                r_n    <= '0;
                r_drop <= 1'b0;
                r_lag  <= '0;
            end else if (w_emit) begin
                r_lag  <= r_lag + LAG_W'(1);
            end
            if (w_emit) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (w_acc) begin
                r_dev[a] <= DEV_W'(w_smp[a]) - DEV_W'(r_mean[a]);
            end
        end
        if (w_emit) begin
            r_o_lag  <= r_lag;
            r_o_lv   <= w_lv;
            r_o_ovf  <= r_drop;
            r_o_last <= (r_lag == w_lim);
            for (int a = 0; a < 3; a++) begin
                r_o_corr[a] <= w_lv ? w_q[a] : '0;
            end
        end
    end

    assign w_ctrl.dev_vld  = r_dev_vld;
    assign w_ctrl.prod_vld = r_prod_vld;
    assign w_ctrl.shift    = (r_st == S_LOAD);
    assign w_ctrl.clear    = w_final;

    assign w_tap[0] = r_dev;
    assign w_sum[MAX_LAGS] = '{default: '0};

    for (genvar l = 0; l < MAX_LAGS; l++) begin : g_cell
        lac_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_dev     (r_dev),
            .i_d_in    (w_tap[l]),
            .o_d_out   (w_tap[l+1]),
            .i_sum_in  (w_sum[l+1]),
            .o_sum_out (w_sum[l])
        );
    end

    for (genvar a = 0; a < 3; a++) begin : g_div
        lac_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_st == S_LOAD),
            .i_sum   (w_sum[0][a]),
            .i_cnt   (w_cnt),
            .i_var   (r_var[a]),
            .o_done  (w_done[a]),
            .o_q     (w_q[a])
        );
    end

    assign o_valid      = r_o_vld;
    assign o_lag_index  = r_o_lag;
    assign o_corr_x     = r_o_corr[0];
    assign o_corr_y     = r_o_corr[1];
    assign o_corr_z     = r_o_corr[2];
    assign o_lag_valid  = r_o_lv;
    assign o_overflowed = r_o_ovf;
    assign o_last_lag   = r_o_last;

`ifndef SYNTHESIS
    a_drop_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_n == CNT_W'(MAX_SAMPLES)) |=> r_drop)
        else $error("full run did not flag dropped sample");
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_LOAD) |-> (!r_dev_vld && !r_prod_vld))
        else $error("lag readout started before sums settled");
    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_final |=> (r_n == '0 && !r_drop && r_st == S_RUN))
        else $error("run state not cleared after final lag");
    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[0] |-> (w_done[1] && w_done[2] && r_st == S_DIV))
        else $error("axis dividers out of step");
`endif

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lac_pkg::*;

    typedef struct {
        logic [LAG_W-1:0] lag;
        logic [Q_W-1:0]   corr [3];
        logic             lag_ok;
        logic             ovf;
        logic             last;
    } t_lag_result;

    class corr_board;
        longint          mean [3];
        longint unsigned var_n [3];
        int              lag_cnt;
        longint          dev_hist [MAX_LAGS][3];
        longint          sums [MAX_LAGS][3];
        int              seen;
        bit              dropped;
        t_lag_result     pending [$];
        int              fails;
        int              results_seen;
        int              runs;

        function new();
            for (int a = 0; a < 3; a++) begin
                mean[a] = 0;
                var_n[a] = 1;
            end
            lag_cnt = 64;
            clear_run();
        endfunction

        function void clear_run();
            foreach (sums[l, a]) begin
                sums[l][a] = 0;
                dev_hist[l][a] = 0;
            end
            seen = 0;
            dropped = 0;
        endfunction

        function void configure(logic [2:0] idx, logic [VAR_W-1:0] data);
            logic signed [23:0] m;
            m = data[23:0];
            case (idx)
                REG_MEAN_X, REG_MEAN_Y, REG_MEAN_Z: mean[idx] = longint'(m);
                REG_VAR_X, REG_VAR_Y, REG_VAR_Z:    var_n[idx - REG_VAR_X] = data;
                REG_LAGCOUNT:                       lag_cnt = data[6:0];
                default: ;
            endcase
        endfunction

        // sum / den in Q1.16, round half away from zero, saturating
        function logic [Q_W-1:0] to_q(longint sum, longint unsigned den);
            bit neg;
            longint unsigned mag, q, r, f, rnd;
            neg = sum < 0;
            mag = neg ? -sum : sum;
            q = mag / den;
            r = mag % den;
            f = 0;
            if (q >= 2) begin
                rnd = 131073;
            end else begin
                for (int i = 0; i < FRAC_STEPS; i++) begin
                    r = r << 1;
                    f = f << 1;
                    if (r >= den) begin
                        r -= den;
                        f |= 1;
                    end
                end
                rnd = (((q << 17) | f) + 1) >> 1;
            end
            if (neg) begin
                if (rnd > 131072) rnd = 131072;
                return Q_W'(64'h40000 - rnd);
            end
            if (rnd > 131071) rnd = 131071;
            return Q_W'(rnd);
        endfunction

        function void note_sample(logic signed [23:0] x, logic signed [23:0] y,
                                  logic signed [23:0] z, logic last);
            longint d [3];
            int lags;
            t_lag_result res;
            longint unsigned vv;
            if (seen >= MAX_SAMPLES) begin
                dropped = 1;
            end else begin
                d[0] = longint'(x) - mean[0];
                d[1] = longint'(y) - mean[1];
                d[2] = longint'(z) - mean[2];
                for (int l = 0; l < MAX_LAGS && l <= seen; l++)
                    for (int a = 0; a < 3; a++)
                        sums[l][a] += d[a] * ((l == 0) ? d[a] : dev_hist[l-1][a]);
                for (int k = MAX_LAGS - 1; k > 0; k--)
                    for (int a = 0; a < 3; a++)
                        dev_hist[k][a] = dev_hist[k-1][a];
                for (int a = 0; a < 3; a++)
                    dev_hist[0][a] = d[a];
                seen++;
            end
            if (!last) return;
            lags = lag_cnt < 1 ? 1 : (lag_cnt > MAX_LAGS ? MAX_LAGS : lag_cnt);
            for (int l = 0; l < lags; l++) begin
                res.lag = LAG_W'(l);
                res.lag_ok = l < seen;
                for (int a = 0; a < 3; a++) begin
                    vv = var_n[a] == 0 ? 1 : var_n[a];
                    res.corr[a] = res.lag_ok ?
                        to_q(sums[l][a], longint'(seen - l) * vv) : '0;
                end
                res.ovf = dropped;
                res.last = l == lags - 1;
                pending.push_back(res);
            end
            runs++;
            clear_run();
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 30) $display("%t mismatch: %s", $realtime, msg);
        endtask

        task check(t_lag_result got);
            t_lag_result exp;
            results_seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result, lag %0d", got.lag));
                return;
            end
            exp = pending.pop_front();
            if (got.lag !== exp.lag)
                report($sformatf("lag %0d, want %0d", got.lag, exp.lag));
            for (int a = 0; a < 3; a++)
                if (got.corr[a] !== exp.corr[a])
                    report($sformatf("lag %0d axis %0d corr %h, want %h",
                                     exp.lag, a, got.corr[a], exp.corr[a]));
            if (got.lag_ok !== exp.lag_ok)
                report($sformatf("lag %0d lag_valid %b", exp.lag, got.lag_ok));
            if (got.ovf !== exp.ovf)
                report($sformatf("lag %0d overflowed %b", exp.lag, got.ovf));
            if (got.last !== exp.last)
                report($sformatf("lag %0d last_lag %b", exp.lag, got.last));
        endtask
    endclass

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    i_cfg_valid = 0;
    logic                    o_cfg_ready;
    logic [2:0]              i_cfg_index = '0;
    logic [VAR_W-1:0]        i_cfg_data = '0;
    logic                    i_valid = 0;
    logic                    o_ready;
    logic signed [23:0]      i_sample_x = '0;
    logic signed [23:0]      i_sample_y = '0;
    logic signed [23:0]      i_sample_z = '0;
    logic                    i_last_sample = 0;
    logic                    o_valid;
    logic                    i_ready = 0;
    logic [LAG_W-1:0]        o_lag_index;
    logic signed [Q_W-1:0]   o_corr_x, o_corr_y, o_corr_z;
    logic                    o_lag_valid, o_overflowed, o_last_lag;

    corr_board board;
    bit        calm;
    int        stall_left;
    int        samples_sent;
    int        amp;

    lag_autocorrelation i_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random back-pressure
    always @(posedge i_clk) begin
        t_lag_result got;
        if (board != null && o_valid && i_ready) begin
            got.lag = o_lag_index;
            got.corr[0] = o_corr_x;
            got.corr[1] = o_corr_y;
            got.corr[2] = o_corr_z;
            got.lag_ok = o_lag_valid;
            got.ovf = o_overflowed;
            got.last = o_last_lag;
            board.check(got);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 0;
        end else begin
            i_ready <= 1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    task write_reg(logic [2:0] idx, logic [VAR_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.configure(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task send_sample(logic signed [23:0] x, logic signed [23:0] y,
                     logic signed [23:0] z, logic last);
        int gap;
        i_valid <= 1;
        i_sample_x <= x;
        i_sample_y <= y;
        i_sample_z <= z;
        i_last_sample <= last;
        do @(posedge i_clk); while (!o_ready);
        board.note_sample(x, y, z, last);
        samples_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task wait_idle();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_sample(int bits);
        logic signed [23:0] v;
        v = 24'($urandom);
        return v >>> (23 - bits);
    endfunction

    task setup(int bits, int lc);
        longint unsigned vr;
        for (int a = 0; a < 3; a++) begin
            write_reg(REG_MEAN_X + 3'(a),
                      VAR_W'($signed(rand_sample(bits > 2 ? bits - 2 : 0))));
            vr = (64'd1 << (2 * bits)) / 3 + $urandom_range(0, 255);
            write_reg(REG_VAR_X + 3'(a), VAR_W'(vr));
        end
        write_reg(REG_LAGCOUNT, VAR_W'(lc));
    endtask

    initial begin
        int n, lc;
        board = new();
        calm = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset settings: tiny variance saturates, lags past count flagged
        send_sample(24'sh7fffff, -24'sh800000, 24'sh0, 0);
        send_sample(-24'sh800000, 24'sh7fffff, 24'sh1, 0);
        send_sample(24'sh7fffff, 24'sh7fffff, -24'sh1, 1);
        wait_idle();
        // single-sample run, zero variance and out-of-range lag counts
        write_reg(REG_VAR_X, '0);
        write_reg(REG_VAR_Y, {VAR_W{1'b1}});
        write_reg(REG_VAR_Z, VAR_W'(48'd1 << 40));
        write_reg(REG_MEAN_X, VAR_W'(24'h800000));
        write_reg(REG_MEAN_Y, VAR_W'(24'h7fffff));
        write_reg(REG_MEAN_Z, VAR_W'(24'hfff000));
        write_reg(REG_LAGCOUNT, VAR_W'(0));
        send_sample(24'sh7fffff, -24'sh800000, 24'sh123456, 1);
        wait_idle();
        write_reg(REG_LAGCOUNT, VAR_W'(127));
        for (int i = 0; i < 6; i++)
            send_sample(rand_sample(23), rand_sample(23), rand_sample(23), i == 5);
        wait_idle();
        write_reg(REG_LAGCOUNT, VAR_W'(65));
        send_sample(24'sh0, 24'sh0, 24'sh0, 1);
        wait_idle();

        // random runs with random settings
        n = 0;
        for (int ph = 0; n < 170; ph++) begin
            calm = (ph % 5 == 3);
            amp = $urandom_range(2, 23);
            case ($urandom_range(0, 5))
                0: lc = 1;
                1: lc = 64;
                2: lc = $urandom_range(65, 127);
                default: lc = $urandom_range(2, 20);
            endcase
            setup(amp, lc);
            repeat ($urandom_range(1, 3)) begin
                int len;
                len = $urandom_range(0, 7) == 0 ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_sample(rand_sample(amp), rand_sample(amp), rand_sample(amp),
                                i == len - 1);
                    n++;
                end
                if ($urandom_range(0, 2) == 0) wait_idle();
            end
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        $display("runs: %0d, samples: %0d, lag results checked: %0d",
                 board.runs, samples_sent, board.results_seen);
        $display("covered saturation, zero variance, lag count limits, lags past count");
        if (board.fails == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
